[design/iee_pkg.sv]
// Shared types, character codes and helper functions for the infix expression evaluator.
// No dependencies.
package iee_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] value;
        logic               error;
    } t_out_beat;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} t_op;

    typedef enum logic [1:0] {CLS_SPACE, CLS_DIGIT, CLS_OPER, CLS_OTHER} t_cls;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHAR, ST_RED, ST_ARITH, ST_POST, ST_LAST, ST_EMIT
    } t_state;

    typedef enum logic [1:0] {POST_PUSH, POST_ZERO, POST_LAST} t_post;

    typedef struct packed {
        logic capture;
        logic digit;
        logic set_sign;
        logic flush;
        logic red_fault;
        logic red_fast;
        logic arith_start;
        logic arith_wb;
        logic push_op;
        logic set_zero;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic have_digit;
        logic last;
        logic op_hi;
        logic opr_nz;
        logic top_hi;
        logic two_opnd;
        logic arith_done;
        logic out_free;
    } t_sts;

    function automatic t_cls classify(input logic [7:0] ch);
        t_cls cls;
        if (ch == CH_SPACE)
            cls = CLS_SPACE;
        else if (ch inside {[CH_ZERO:CH_NINE]})
            cls = CLS_DIGIT;
        else if (ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH})
            cls = CLS_OPER;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

    function automatic t_op op_of(input logic [7:0] ch);
        t_op op;
        case (ch)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            default:  op = OP_DIV;
        endcase
        return op;
    endfunction

    function automatic logic is_hi(input t_op op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

[design/infix_integer_expression_evaluator.sv]
// Top level of the infix integer expression evaluator: controller plus datapath.
// Depends on iee_pkg, iee_ctrl, iee_datapath.
//
//   channel  direction  handshake                 beat
//   in       input      i_in_valid / o_in_ready   i_in_beat  (ch, last)
//   out      output     o_out_valid / i_out_ready o_out_beat (value, error)
//
// A space, digit or sign beat passes idle and char states. An operator or other character
// after a number adds flush, each add/sub or mul/div reduction (mul/div in the iterative
// unit), loop exit and a push or zero set; at most two reductions per operator.
// A last beat adds flush, the final reductions, loop exit, post and emit steps.
// Synchronous active-low reset clears all control state; no clearing pass.
// A result waiting in the output register does not block input; only the next emit waits.
module infix_integer_expression_evaluator import iee_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    t_cmd cmd;
    t_sts sts;

    iee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    iee_datapath #(.VALUE_BITS(VALUE_BITS)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_beat   (i_in_beat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

[design/iee_arith.sv]
// Iterative multiply / divide unit: one bit per cycle, shift-add multiply and
// restoring signed divide truncating toward zero. Depends on iee_pkg.
module iee_arith import iee_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_is_div,
    input  logic [VALUE_BITS-1:0] i_a,
    input  logic [VALUE_BITS-1:0] i_b,
    output logic                  o_done,
    output logic                  o_dz,
    output logic [VALUE_BITS-1:0] o_res
);

    localparam int W  = VALUE_BITS;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic          r_dz;
    logic          r_div;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_sh;
    logic [W-1:0]  r_opd;

    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;
    logic [W:0]    trial;
    logic          ge;
    logic          b_zero;

    assign mag_a  = i_a[W-1] ? (W'(0) - i_a) : i_a;
    assign mag_b  = i_b[W-1] ? (W'(0) - i_b) : i_b;
    assign b_zero = (i_b == '0);
    assign trial  = {r_acc, r_sh[W-1]} - {1'b0, r_opd};
    assign ge     = ~trial[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_dz   <= 1'b0;
        end else begin
            if (i_start) begin
                r_div <= i_is_div;
                r_acc <= '0;
                r_cnt <= CW'(W - 1);
                r_dz  <= i_is_div && b_zero;
                if (i_is_div && b_zero) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_sh   <= '0;
                    r_neg  <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                    r_sh   <= i_is_div ? mag_a : i_b;
                    r_opd  <= i_is_div ? mag_b : i_a;
                    r_neg  <= i_a[W-1] ^ i_b[W-1];
                end
            end else if (r_busy) begin
                if (r_div) begin
                    r_acc <= ge ? trial[W-1:0] : {r_acc[W-2:0], r_sh[W-1]};
                    r_sh  <= {r_sh[W-2:0], ge};
                end else begin
                    if (r_sh[0])
                        r_acc <= r_acc + r_opd;
                    r_opd <= {r_opd[W-2:0], 1'b0};
                    r_sh  <= {1'b0, r_sh[W-1:1]};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                    r_cnt  <= r_cnt - CW'(1);
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_dz   = r_dz;
    assign o_res  = r_div ? (r_neg ? (W'(0) - r_sh) : r_sh) : r_acc;

endmodule

[design/iee_datapath.sv]
// Datapath: number accumulator, shift-register operand and operator stacks,
// add/sub, the mul/div unit and the result register. Depends on iee_pkg, iee_arith.
module iee_datapath import iee_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_beat o_out_beat
);

    localparam int W = VALUE_BITS;

    logic [7:0]  r_ch;
    logic        r_last;
    logic [W-1:0] r_acc;
    logic        r_neg;
    logic        r_have;
    logic [W-1:0] r_s0;
    logic [W-1:0] r_s1;
    logic [W-1:0] r_s2;
    logic [1:0]  r_opnd_cnt;
    t_op         r_opr0;
    t_op         r_opr1;
    logic [1:0]  r_opr_cnt;
    logic        r_fault;
    logic        r_zero;
    logic        r_out_valid;
    t_out_beat   r_out;

    logic [W-1:0] acc_next;
    logic [W-1:0] num_val;
    logic [W-1:0] addsub;
    logic [W-1:0] wb_val;
    logic [W-1:0] fin_val;
    logic         fin_fault;
    logic         arith_done;
    logic         arith_dz;
    logic [W-1:0] arith_res;

    iee_arith #(.VALUE_BITS(W)) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.arith_start),
        .i_is_div (r_opr0 == OP_DIV),
        .i_a      (r_s1),
        .i_b      (r_s0),
        .o_done   (arith_done),
        .o_dz     (arith_dz),
        .o_res    (arith_res)
    );

    assign acc_next  = (r_acc << 3) + (r_acc << 1) + W'(r_ch[3:0]);
    assign num_val   = r_neg ? (W'(0) - r_acc) : r_acc;
    assign addsub    = (r_opr0 == OP_SUB) ? (r_s1 - r_s0) : (r_s1 + r_s0);
    assign wb_val    = i_cmd.red_fast ? addsub : arith_res;
    assign fin_fault = r_fault || (r_opnd_cnt == 2'd0);
    assign fin_val   = (fin_fault || r_zero) ? '0 : r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_have      <= 1'b0;
            r_opnd_cnt  <= '0;
            r_opr_cnt   <= '0;
            r_fault     <= 1'b0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_ch   <= i_in_beat.ch;
                r_last <= i_in_beat.last;
            end
            if (i_cmd.digit) begin
                r_acc  <= acc_next;
                r_have <= 1'b1;
            end
            if (i_cmd.set_sign)
                r_neg <= (r_ch == CH_MINUS);
            if (i_cmd.flush && r_have) begin
                if (r_opnd_cnt != 2'd3) begin
                    r_s0       <= num_val;
                    r_s1       <= r_s0;
                    r_s2       <= r_s1;
                    r_opnd_cnt <= r_opnd_cnt + 2'd1;
                end else begin
                    r_fault <= 1'b1;
                end
                r_acc  <= '0;
                r_neg  <= 1'b0;
                r_have <= 1'b0;
            end
            if (i_cmd.red_fault) begin
                r_fault    <= 1'b1;
                r_opnd_cnt <= '0;
                r_opr_cnt  <= '0;
            end
            if (i_cmd.red_fast || i_cmd.arith_wb) begin
                r_s0       <= wb_val;
                r_s1       <= r_s2;
                r_opnd_cnt <= r_opnd_cnt - 2'd1;
                r_opr0     <= r_opr1;
                r_opr_cnt  <= r_opr_cnt - 2'd1;
                if (i_cmd.arith_wb && arith_dz)
                    r_fault <= 1'b1;
            end
            if (i_cmd.push_op) begin
                if (r_opr_cnt != 2'd2) begin
                    r_opr0    <= op_of(r_ch);
                    r_opr1    <= r_opr0;
                    r_opr_cnt <= r_opr_cnt + 2'd1;
                end else begin
                    r_fault <= 1'b1;
                end
            end
            if (i_cmd.set_zero) begin
                r_opnd_cnt <= '0;
                r_zero     <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out.value <= 32'(signed'(fin_val));
                r_out.error <= fin_fault;
                r_acc       <= '0;
                r_neg       <= 1'b0;
                r_have      <= 1'b0;
                r_opnd_cnt  <= '0;
                r_opr_cnt   <= '0;
                r_fault     <= 1'b0;
                r_zero      <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.cls        = classify(r_ch);
        o_sts.have_digit = r_have;
        o_sts.last       = r_last;
        o_sts.op_hi      = is_hi(op_of(r_ch));
        o_sts.opr_nz     = (r_opr_cnt != 2'd0);
        o_sts.top_hi     = is_hi(r_opr0);
        o_sts.two_opnd   = (r_opnd_cnt >= 2'd2);
        o_sts.arith_done = arith_done;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

[design/iee_ctrl.sv]
// Controller state machine: sequences character handling, reductions and the final flush.
// Depends on iee_pkg.
module iee_ctrl import iee_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_hi_only, n_hi_only;
    t_post  r_post, n_post;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hi_only <= 1'b0;
            r_post    <= POST_PUSH;
        end else begin
            r_state   <= n_state;
            r_hi_only <= n_hi_only;
            r_post    <= n_post;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_hi_only  = r_hi_only;
        n_post     = r_post;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CHAR;
                end
            end
            ST_CHAR: begin
                n_state = i_sts.last ? ST_LAST : ST_IDLE;
                case (i_sts.cls)
                    CLS_SPACE: ;
                    CLS_DIGIT: o_cmd.digit = 1'b1;
                    default: begin
                        if (i_sts.have_digit) begin
                            o_cmd.flush = 1'b1;
                            n_hi_only   = (i_sts.cls == CLS_OPER) && i_sts.op_hi;
                            n_post      = (i_sts.cls == CLS_OPER) ? POST_PUSH : POST_ZERO;
                            n_state     = ST_RED;
                        end else begin
                            o_cmd.set_sign = 1'b1;
                        end
                    end
                endcase
            end
            ST_RED: begin
                if (i_sts.opr_nz && (!r_hi_only || i_sts.top_hi)) begin
                    if (!i_sts.two_opnd) begin
                        o_cmd.red_fault = 1'b1;
                        n_state         = ST_POST;
                    end else if (i_sts.top_hi) begin
                        o_cmd.arith_start = 1'b1;
                        n_state           = ST_ARITH;
                    end else begin
                        o_cmd.red_fast = 1'b1;
                    end
                end else begin
                    n_state = ST_POST;
                end
            end
            ST_ARITH: begin
                if (i_sts.arith_done) begin
                    o_cmd.arith_wb = 1'b1;
                    n_state        = ST_RED;
                end
            end
            ST_POST: begin
                case (r_post)
                    POST_PUSH: begin
                        o_cmd.push_op = 1'b1;
                        n_state       = i_sts.last ? ST_LAST : ST_IDLE;
                    end
                    POST_ZERO: begin
                        o_cmd.set_zero = 1'b1;
                        n_state        = i_sts.last ? ST_LAST : ST_IDLE;
                    end
                    default: n_state = ST_EMIT;
                endcase
            end
            ST_LAST: begin
                o_cmd.flush = 1'b1;
                n_hi_only   = 1'b0;
                n_post      = POST_LAST;
                n_state     = ST_RED;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[dv/infix_integer_expression_evaluator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for infix_integer_expression_evaluator: character beats go in,
// an in-file predictor computes each expression value, and output beats are compared.
// Depends on iee_pkg and the design sources.
module infix_integer_expression_evaluator_test import iee_pkg::*; ();

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} t_rx_mode;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_beat = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    infix_integer_expression_evaluator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (o_out_beat)
    );

    t_in_beat   pending_beats[$];
    t_out_beat  expected_values[$];
    logic [7:0] expr_buf[$];
    int         mismatches = 0;
    int         exprs_built = 0;
    int         chars_taken = 0;
    int         results_seen = 0;
    int         error_results = 0;

    // evaluator state mirror
    logic [31:0] acc = '0;
    logic        neg = 1'b0;
    logic        digit_seen = 1'b0;
    logic [31:0] vals[3];
    int          nvals = 0;
    t_op         ops[2];
    int          nops = 0;
    logic        faulted = 1'b0;
    logic        zeroed = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #8_000_000;
        $display("infix_integer_expression_evaluator: mismatch");
        $finish;
    end

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("ERROR %0t: %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    function automatic int rank(input t_op op);
        return (op == OP_MUL || op == OP_DIV) ? 2 : 1;
    endfunction

    function automatic logic [31:0] combine(input logic [31:0] a, input logic [31:0] b,
                                            input t_op op);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            default: begin
                if (b == 32'd0) begin
                    faulted = 1'b1;
                    return 32'd0;
                end
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                if (a[31] ^ b[31])
                    q = -q;
                return q;
            end
        endcase
    endfunction

    function automatic void push_val(input logic [31:0] v);
        if (nvals < 3) begin
            vals[nvals] = v;
            nvals++;
        end else begin
            faulted = 1'b1;
        end
    endfunction

    function automatic void push_op(input t_op op);
        if (nops < 2) begin
            ops[nops] = op;
            nops++;
        end else begin
            faulted = 1'b1;
        end
    endfunction

    function automatic void fold(input int min_rank);
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        while (nops > 0 && nops <= 2) begin
            op = ops[nops-1];
            if (rank(op) < min_rank)
                break;
            if (nvals < 2 || nvals > 3) begin
                faulted = 1'b1;
                nops = 0;
                nvals = 0;
                return;
            end
            b = vals[nvals-1];
            a = vals[nvals-2];
            nvals -= 2;
            push_val(combine(a, b, op));
            nops--;
        end
    endfunction

    function automatic void take_number();
        if (digit_seen) begin
            push_val(neg ? -acc : acc);
            acc = '0;
            neg = 1'b0;
            digit_seen = 1'b0;
        end
    endfunction

    function automatic void eval_char(input t_in_beat b);
        logic [7:0]  c;
        t_op         op;
        logic        is_op;
        logic [31:0] v;
        t_out_beat   r;
        c = b.ch;
        is_op = 1'b1;
        case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default: begin
                op = OP_ADD;
                is_op = 1'b0;
            end
        endcase
        if (c == CH_SPACE) begin
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            acc = acc * 32'd10 + 32'(c - CH_ZERO);
            digit_seen = 1'b1;
        end else if (digit_seen) begin
            take_number();
            if (is_op) begin
                fold(rank(op));
                push_op(op);
            end else begin
                fold(0);
                nvals = 0;
                zeroed = 1'b1;
            end
        end else begin
            neg = (c == CH_MINUS);
        end
        if (b.last) begin
            v = '0;
            take_number();
            fold(0);
            if (nvals < 1 || nvals > 3)
                faulted = 1'b1;
            else if (!zeroed)
                v = vals[nvals-1];
            if (faulted)
                v = '0;
            r.value = v;
            r.error = faulted;
            expected_values.insert(expected_values.size(), r);
            acc = '0;
            neg = 1'b0;
            digit_seen = 1'b0;
            nvals = 0;
            nops = 0;
            faulted = 1'b0;
            zeroed = 1'b0;
        end
    endfunction

    function automatic void put_char(input logic [7:0] c);
        expr_buf.insert(expr_buf.size(), c);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    function automatic void end_expr();
        t_in_beat b;
        for (int i = 0; i < expr_buf.size(); i++) begin
            b.ch = expr_buf[i];
            b.last = (i == expr_buf.size() - 1);
            pending_beats.insert(pending_beats.size(), b);
        end
        expr_buf.delete();
        exprs_built++;
    endfunction

    function automatic logic [7:0] odd_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS ||
               c == CH_MINUS || c == CH_STAR || c == CH_SLASH);
        return c;
    endfunction

    function automatic void put_spaces();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) put_char(CH_SPACE);
    endfunction

    function automatic void put_signs();
        string signs;
        int    r;
        signs = "+-*/";
        repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, 6);
            if (r <= 2)
                put_char(CH_MINUS);
            else if (r <= 5)
                put_char(signs[$urandom_range(0, 3)]);
            else
                put_char(odd_char());
        end
    endfunction

    function automatic void put_number();
        string       extremes[6];
        int          r;
        int unsigned u;
        extremes = '{"0", "1", "2147483647", "2147483648", "4294967295", "4294967296"};
        r = $urandom_range(0, 19);
        if (r <= 9) begin
            put_text($sformatf("%0d", $urandom_range(0, 99)));
        end else if (r <= 13) begin
            u = $urandom;
            put_text($sformatf("%0d", u));
        end else if (r <= 16) begin
            put_text(extremes[$urandom_range(0, 5)]);
        end else begin
            repeat ($urandom_range(11, 14))
                put_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void put_random_expr();
        string specials[7];
        string opchars;
        int    kind;
        int    n;
        logic  div_next;
        logic  [7:0] sep;
        specials = '{"-2147483648/-1", "2147483647+1", "65536*65536", "-2147483648*-1",
                     "0-2147483648-1", "10/-3", "-10/3"};
        opchars = "+-*/";
        kind = $urandom_range(0, 19);
        div_next = 1'b0;
        if (kind == 0) begin
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 1))
                    put_char(8'($urandom_range(0, 255)));
                else
                    put_text(" 9+-*/0");
            end
        end else if (kind == 1) begin
            put_text(specials[$urandom_range(0, 6)]);
        end else begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
                put_spaces();
                if ($urandom_range(0, 3) == 0)
                    put_signs();
                put_spaces();
                if (div_next && $urandom_range(0, 7) == 0)
                    put_char(CH_ZERO);
                else
                    put_number();
                put_spaces();
                if (i < n - 1) begin
                    if (kind == 2 && $urandom_range(0, 2) == 0)
                        sep = odd_char();
                    else
                        sep = opchars[$urandom_range(0, 3)];
                    div_next = (sep == CH_SLASH);
                    put_char(sep);
                end
            end
            if (kind == 3) begin
                put_char(opchars[$urandom_range(0, 3)]);
                put_spaces();
            end
        end
        end_expr();
    endfunction

    // sender: bursts of random length separated by random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                eval_char(in_beat);
                chars_taken++;
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    in_beat <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 60);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(1, 4);
                            default: gap_left = $urandom_range(5, 45);
                        endcase
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern switches between modes
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [15:0] rx_pattern = '1;
    logic        rx_next;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
            rx_pattern = 16'($urandom);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:    rx_next = 1'b1;
            RX_COIN:    rx_next = 1'($urandom_range(0, 1));
            RX_PATTERN: begin
                rx_next = rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            end
            default:    rx_next = ($urandom_range(0, 7) == 0);
        endcase
        out_ready <= rx_next;
    end

    t_out_beat want_beat;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (expected_values.size() == 0) begin
                flag("unexpected result beat", 32'd0, o_out_beat.value);
            end else begin
                want_beat = expected_values.pop_front();
                if (want_beat.error)
                    error_results++;
                if (o_out_beat.value !== want_beat.value)
                    flag("value", want_beat.value, o_out_beat.value);
                if (o_out_beat.error !== want_beat.error)
                    flag("error", 32'(want_beat.error), 32'(o_out_beat.error));
            end
        end
    end

    initial begin
        put_text("-7/2");
        end_expr();
        put_text("1-2*3+4");
        end_expr();
        put_text("9/0");
        end_expr();
        put_text("5-");
        end_expr();
        put_text("8");
        put_char(8'hFF);
        put_text("2");
        end_expr();
        put_text("+-3");
        end_expr();
        put_text(" 3");
        end_expr();
        put_char(8'h00);
        end_expr();
        while (pending_beats.size() < 1375)
            put_random_expr();

        while (pending_beats.size() != 0 || in_valid || expected_values.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (expected_values.size() != 0)
            flag("results outstanding", 32'd0, 32'(expected_values.size()));
        $display("Ran %0d expressions, %0d character beats; %0d results, %0d with error set.",
                 exprs_built, chars_taken, results_seen, error_results);
        if (mismatches == 0) begin
            $display("infix_integer_expression_evaluator: match");
        end else begin
            $display("infix_integer_expression_evaluator: mismatch");
        end
        $finish;
    end

endmodule
